@@ rtl/core/positive_sample_slot_averager_core_assert.svh @@
// Assertion macros shared by the slot averager RTL.
// Used by files that `include this header; needs clk_i and rst_ni in scope.
`ifndef POSITIVE_SAMPLE_SLOT_AVERAGER_CORE_ASSERT_SVH
`define POSITIVE_SAMPLE_SLOT_AVERAGER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PSSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("slot averager assertion failed");
`define PSSA_ASSERT_NEVER(lbl, expr) `PSSA_ASSERT(lbl, !(expr))
`else
`define PSSA_ASSERT(lbl, prop)
`define PSSA_ASSERT_NEVER(lbl, expr)
`endif
`endif

@@ rtl/core/pssa_pkg.sv @@
// Shared widths and constants for the positive sample slot averager.
// No dependencies.
package pssa_pkg;
  localparam int TEMP_W = 16;
  localparam int AVG_W  = 15;
  localparam int IDX_W  = 6;
  localparam int CFG_W  = 7;
  localparam logic [CFG_W-1:0] SLOTS_RESET = 7'd24;
endpackage

@@ rtl/core/pssa_if.sv @@
// Valid/ready channel interfaces for samples and per-slot results.
// Depends on pssa_pkg.
interface pssa_in_if import pssa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;
  logic                     final_sample;

  modport source (output valid, temperature, final_sample, input ready);
  modport sink (input valid, temperature, final_sample, output ready);
endinterface

interface pssa_out_if import pssa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] slot_index;
  logic [AVG_W-1:0] average;
  logic             last_of_run;

  modport source (output valid, slot_index, average, last_of_run, input ready);
  modport sink (input valid, slot_index, average, last_of_run, output ready);
endinterface

@@ rtl/core/positive_sample_slot_averager_core.sv @@
// Per-slot mean of positive temperature samples. A sample is read from the
// store (ST_IDLE), then added and written back (ST_UPD); no new sample is
// accepted until that is done. The sample flagged final starts a readout:
// each slot in use goes through a store read, the shared bit-serial divider
// and the output load, plus any output stall; slots come out in order,
// the last one flagged. The store holds one word per slot; a valid bit per
// slot, cleared at reset and after each readout, makes untouched slots read
// as zero, so no clearing pass is needed.
`include "positive_sample_slot_averager_core_assert.svh"
module positive_sample_slot_averager_core import pssa_pkg::*; #(
  parameter int MAX_SLOTS  = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  pssa_in_if.sink          sample_i,
  pssa_out_if.source       result_o
);
  localparam int AW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int NW      = $clog2(MAX_SLOTS + 1);
  localparam int SUM_W   = COUNT_BITS + AVG_W;
  localparam int WORD_W  = SUM_W + COUNT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPD, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_DIV
  } state_e;

  state_e                   state_q;
  logic [CFG_W-1:0]         slots_q;
  logic [AW-1:0]            pos_q, idx_q, addr_q;
  logic [MAX_SLOTS-1:0]     valid_q;
  logic [AVG_W-1:0]         temp_q;
  logic                     temp_pos_q, final_q;
  logic                     out_valid_q, out_last_q;
  logic [IDX_W-1:0]         out_idx_q;
  logic [AVG_W-1:0]         out_avg_q;
  logic                     cnt_zero_q;

  logic [NW-1:0]            n_eff;
  logic [AW-1:0]            pos_eff, pos_next;
  logic                     accept, out_load, out_last;
  logic                     ram_re, ram_we;
  logic [AW-1:0]            ram_raddr;
  logic [WORD_W-1:0]        ram_rdata, ram_wdata;
  logic [SUM_W-1:0]         cur_sum;
  logic [COUNT_BITS-1:0]    cur_cnt;
  logic                     div_start, div_busy, div_done;
  logic [AVG_W-1:0]         div_quo;

  always_comb begin
    if (slots_q == '0) begin
      n_eff = NW'(1);
    end else if (slots_q > CFG_W'(MAX_SLOTS)) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = slots_q[NW-1:0];
    end
    // Wrap a stale position left over from a register change.
    pos_eff  = (NW'(pos_q) >= n_eff) ? '0 : pos_q;
    pos_next = (NW'(pos_eff) + NW'(1) >= n_eff) ? '0 : AW'(pos_eff + 1'b1);
  end

  assign sample_i.ready = (state_q == ST_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;

  assign ram_re    = accept || (state_q == ST_EMIT_RD);
  assign ram_raddr = (state_q == ST_EMIT_RD) ? idx_q : pos_eff;

  // Slots never written since the last readout read as zero.
  assign cur_sum = valid_q[addr_q] ? ram_rdata[WORD_W-1:COUNT_BITS] : '0;
  assign cur_cnt = valid_q[addr_q] ? ram_rdata[COUNT_BITS-1:0] : '0;

  // Saturated slots drop further samples entirely.
  assign ram_we    = (state_q == ST_UPD) && temp_pos_q && (cur_cnt != '1);
  assign ram_wdata = {cur_sum + SUM_W'(temp_q), cur_cnt + 1'b1};

  assign div_start = (state_q == ST_EMIT_LD);
  assign out_last  = (NW'(idx_q) + NW'(1) == n_eff);
  assign out_load  = (state_q == ST_EMIT_DIV) && div_done
                     && (!out_valid_q || result_o.ready);

  pssa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pssa_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_sum),
    .divisor_i  (cur_cnt),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slots_q     <= SLOTS_RESET;
      pos_q       <= '0;
      idx_q       <= '0;
      addr_q      <= '0;
      valid_q     <= '0;
      temp_q      <= '0;
      temp_pos_q  <= 1'b0;
      final_q     <= 1'b0;
      cnt_zero_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
      out_avg_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        slots_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            addr_q     <= pos_eff;
            pos_q      <= pos_next;
            temp_q     <= sample_i.temperature[AVG_W-1:0];
            temp_pos_q <= !sample_i.temperature[TEMP_W-1]
                          && (sample_i.temperature != '0);
            final_q    <= sample_i.final_sample;
            state_q    <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (ram_we) begin
            valid_q[addr_q] <= 1'b1;
          end
          idx_q   <= '0;
          state_q <= final_q ? ST_EMIT_RD : ST_IDLE;
        end
        ST_EMIT_RD: begin
          addr_q  <= idx_q;
          state_q <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          cnt_zero_q <= (cur_cnt == '0);
          state_q    <= ST_EMIT_DIV;
        end
        ST_EMIT_DIV: begin
          if (out_load) begin
            out_idx_q  <= IDX_W'(idx_q);
            out_avg_q  <= cnt_zero_q ? '0 : div_quo;
            out_last_q <= out_last;
            if (out_last) begin
              // Readout done: empty the store and restart the day.
              valid_q <= '0;
              pos_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= AW'(idx_q + 1'b1);
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.slot_index  = out_idx_q;
  assign result_o.average     = out_avg_q;
  assign result_o.last_of_run = out_last_q;

  `PSSA_ASSERT(a_accept_to_upd, accept |=> (state_q == ST_UPD))
  `PSSA_ASSERT_NEVER(a_start_while_busy, div_start && div_busy)
  `PSSA_ASSERT_NEVER(a_overwrite_result, out_load && out_valid_q && !result_o.ready)
  `PSSA_ASSERT(a_clear_after_run,
    (out_load && out_last) |=> (valid_q == '0 && pos_q == '0 && out_last_q))
endmodule

@@ rtl/core/pssa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pssa_ram #(
  parameter int WIDTH = 47,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/core/pssa_div.sv @@
// Restoring divider, one quotient bit per cycle, for the slot averages.
// Depends on pssa_pkg (quotient width).
module pssa_div import pssa_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COUNT_BITS+AVG_W-1:0]   dividend_i,
  input  logic [COUNT_BITS-1:0]         divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [AVG_W-1:0]              quotient_o
);
  localparam int StepW = $clog2(AVG_W + 1);

  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS-1:0] dvs_q;
  logic [AVG_W-1:0]      low_q;
  logic [AVG_W-1:0]      quo_q;
  logic [StepW-1:0]      step_q;
  logic                  busy_q, done_q;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  // The quotient is known to fit AVG_W bits, so the upper dividend bits
  // already form a remainder below the divisor.
  always_comb begin
    trial = {rem_q, low_q[AVG_W-1]};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? COUNT_BITS'(trial - {1'b0, dvs_q}) : trial[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      low_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= StepW'(AVG_W);
      rem_q  <= dividend_i[COUNT_BITS+AVG_W-1:AVG_W];
      low_q  <= dividend_i[AVG_W-1:0];
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      low_q  <= {low_q[AVG_W-2:0], 1'b0};
      quo_q  <= {quo_q[AVG_W-2:0], fits};
      step_q <= step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

@@ test/pssa_mean_checker.sv @@
// Scoreboard for the slot averager: keeps its own per-slot sums and counts of
// the accepted samples and checks every result item's slot index, mean and last flag.
// Depends on pssa_pkg and the channel interfaces in pssa_if.sv.
module pssa_mean_checker import pssa_pkg::*; #(
  parameter int MAX_SLOTS  = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  pssa_in_if               sample_i,
  pssa_out_if              result_o,
  output int               means_due_o,
  output int               mismatches_o
);
  localparam int SUM_W     = 31;
  localparam int DUE_DEPTH = 256;
  localparam logic [COUNT_BITS-1:0] HITS_MAX = '1;

  typedef struct packed {
    logic [IDX_W-1:0] slot_index;
    logic [AVG_W-1:0] average;
    logic             last_of_run;
  } slot_mean_t;

  logic [SUM_W-1:0]      slot_total [MAX_SLOTS];
  logic [COUNT_BITS-1:0] slot_hits  [MAX_SLOTS];
  int                    next_slot;
  logic [CFG_W-1:0]      slots_cfg;
  slot_mean_t            due_buf [DUE_DEPTH];
  int                    due_head = 0;
  int                    due_tail = 0;
  int                    mismatches = 0;

  // Zero acts as one slot, anything past the store size as the full store.
  function automatic int active_slots();
    if (slots_cfg == '0) return 1;
    if (slots_cfg > MAX_SLOTS) return MAX_SLOTS;
    return int'(slots_cfg);
  endfunction

  task automatic clear_store();
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_total[i] = '0;
      slot_hits[i]  = '0;
    end
    next_slot = 0;
  endtask

  task automatic add_due(input slot_mean_t m);
    if (due_tail - due_head >= DUE_DEPTH) begin
      $error("expected result buffer overflow");
      mismatches++;
    end else begin
      due_buf[due_tail % DUE_DEPTH] = m;
      due_tail++;
    end
  endtask

  task automatic accumulate_sample(input logic [TEMP_W-1:0] t, input logic fin);
    int         n;
    int         pos;
    slot_mean_t m;
    n   = active_slots();
    pos = next_slot;
    // A position left over from a wider setting restarts at slot 0.
    if (pos >= n) pos = 0;
    // Add strictly positive samples only; drop them once the count saturates.
    if (!t[TEMP_W-1] && t != '0 && slot_hits[pos] != HITS_MAX) begin
      slot_hits[pos]  = slot_hits[pos] + 1'b1;
      slot_total[pos] = slot_total[pos] + SUM_W'(t);
    end
    pos++;
    if (pos >= n) pos = 0;
    next_slot = pos;
    if (fin) begin
      for (int i = 0; i < n; i++) begin
        m.slot_index  = IDX_W'(i);
        m.average     = (slot_hits[i] == '0) ? '0 : AVG_W'(slot_total[i] / slot_hits[i]);
        m.last_of_run = (i == n - 1);
        add_due(m);
      end
      clear_store();
    end
  endtask

  task automatic check_result();
    slot_mean_t want;
    if (due_tail == due_head) begin
      $error("unexpected result item: slot_index %0d average %0d last_of_run %0b",
             result_o.slot_index, result_o.average, result_o.last_of_run);
      mismatches++;
    end else begin
      want = due_buf[due_head % DUE_DEPTH];
      due_head++;
      if (result_o.slot_index !== want.slot_index) begin
        $error("slot_index: expected %0d, got %0d", want.slot_index, result_o.slot_index);
        mismatches++;
      end
      if (result_o.average !== want.average) begin
        $error("average: expected %0d, got %0d", want.average, result_o.average);
        mismatches++;
      end
      if (result_o.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, result_o.last_of_run);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_store();
      slots_cfg = SLOTS_RESET;
      due_head  = 0;
      due_tail  = 0;
      means_due_o  <= 0;
      mismatches_o <= mismatches;
    end else begin
      if (cfg_we_i) slots_cfg = cfg_wdata_i;
      // Retire results before new samples so a same-edge final cannot satisfy them.
      if (result_o.valid && result_o.ready) check_result();
      if (sample_i.valid && sample_i.ready) begin
        accumulate_sample(sample_i.temperature, sample_i.final_sample);
      end
      means_due_o  <= due_tail - due_head;
      mismatches_o <= mismatches;
    end
  end
endmodule

@@ test/positive_sample_slot_averager_core_tb.sv @@
// Testbench top for the slot averager: drives samples, slot settings and
// output stalls; the verdict comes from the failure count of pssa_mean_checker.
// Depends on pssa_pkg, pssa_if.sv, pssa_mean_checker and the core RTL.
module positive_sample_slot_averager_core_tb;
  import pssa_pkg::*;

  localparam int RANDOM_ITEMS  = 392;
  localparam int SLOT_CAP      = 64;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 4_000_000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  pssa_in_if  sample_ch ();
  pssa_out_if result_ch ();

  int          means_due;
  int          mismatches;
  int unsigned cycle_count   = 0;
  logic        hold_off_req;
  bit          hold_done     = 1'b0;
  int          burst_left    = 0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  positive_sample_slot_averager_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_ch),
    .result_o    (result_ch)
  );

  pssa_mean_checker u_means (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample_ch),
    .result_o     (result_ch),
    .means_due_o  (means_due),
    .mismatches_o (mismatches)
  );

  function automatic logic [TEMP_W-1:0] pick_temperature();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return TEMP_W'($urandom_range(1, 32767));
    if (sel < 50) return TEMP_W'($urandom_range(1, 16));
    if (sel < 57) return TEMP_W'(32767 - $urandom_range(0, 8));
    if (sel < 65) return '0;
    if (sel < 82) return TEMP_W'(-$urandom_range(1, 32768));
    return TEMP_W'($urandom());
  endfunction

  function automatic int pick_slots();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return $urandom_range(1, 6);
    if (sel < 75) return $urandom_range(7, 20);
    if (sel < 85) return $urandom_range(21, 63);
    if (sel < 90) return SLOT_CAP;
    if (sel < 94) return 0;
    return $urandom_range(SLOT_CAP + 1, 127);
  endfunction

  task automatic send_sample(input logic [TEMP_W-1:0] t, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.temperature  <= t;
    sample_ch.final_sample <= fin;
    @(posedge clk_i);
    while (sample_ch.ready !== 1'b1) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic sender_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    sender_idle();
    while (means_due != 0) @(posedge clk_i);
  endtask

  // Let a trailing non-final sample finish before touching the register.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_slots(input logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random open/stall runs, plus one long hold-off on request.
  initial begin : result_sink
    int left;
    bit rdy_on;
    left   = 0;
    rdy_on = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
        left      = 0;
      end
      if (left == 0) begin
        rdy_on = !rdy_on;
        if (rdy_on) left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 6);
        else left = $urandom_range(1, 7);
        result_ch.ready <= rdy_on;
      end
      left--;
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int n;
    int len;
    int sets;
    int slots_v;
    int samples_sent;
    bit broken;
    bit first;
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_wdata_i            <= '0;
    sample_ch.valid        <= 1'b0;
    sample_ch.temperature  <= '0;
    sample_ch.final_sample <= 1'b0;
    hold_off_req           <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting of 24 slots, set ends early in the first day.
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0100, 1'b0);
    send_sample(16'h2AAA, 1'b0);
    send_sample(16'h5555, 1'b1);

    // One slot: truncating mean.
    settle();
    write_slots(7'd1);
    send_sample(16'd5, 1'b0);
    send_sample(16'd7, 1'b0);
    send_sample(16'd8, 1'b1);

    // Zero slots behaves as one.
    settle();
    write_slots(7'd0);
    send_sample(16'd100, 1'b0);
    send_sample(16'd3, 1'b1);

    // Shrink the slot count mid-set: position wraps to slot 0, sums are kept.
    settle();
    write_slots(7'd64);
    send_sample(16'd9, 1'b0);
    send_sample(16'd10, 1'b0);
    send_sample(16'd11, 1'b0);
    settle();
    write_slots(7'd2);
    send_sample(16'h7FFF, 1'b1);

    // Oversized setting clamps to the full store.
    settle();
    write_slots(7'd127);
    send_sample(16'hFFFB, 1'b1);

    samples_sent = 0;
    first        = 1'b1;
    while (samples_sent < RANDOM_ITEMS) begin
      settle();
      slots_v = first ? $urandom_range(2, 6) : pick_slots();
      write_slots(CFG_W'(slots_v));
      n    = (slots_v == 0) ? 1 : (slots_v > SLOT_CAP) ? SLOT_CAP : slots_v;
      sets = first ? 2 : $urandom_range(1, 3);
      for (int s = 0; s < sets; s++) begin
        len = n * $urandom_range(0, 2) + $urandom_range(1, n);
        if (len > 100) len = $urandom_range(n / 2, 100);
        // Now and then leave a set unfinished so it runs into the next one.
        broken = !first && ($urandom_range(0, 7) == 0);
        for (int k = 0; k < len; k++) begin
          // Block the result side on the first readout so the input backs up.
          if (first && s == 0 && k == len - 1) hold_off_req <= 1'b1;
          send_sample(pick_temperature(), (k == len - 1) && !broken);
          samples_sent++;
        end
        if (!first && $urandom_range(0, 3) == 0) wait_drained();
      end
      first = 1'b0;
    end

    sender_idle();
    while (means_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ positive_sample_slot_averager_core.f @@
+incdir+rtl/core
rtl/core/pssa_pkg.sv
rtl/core/pssa_if.sv
rtl/core/pssa_ram.sv
rtl/core/pssa_div.sv
rtl/core/positive_sample_slot_averager_core.sv
test/pssa_mean_checker.sv
test/positive_sample_slot_averager_core_tb.sv
